@@ design/dtmf_pkg.sv @@
package dtmf_pkg;

   localparam int PHASE_W = 24;
   localparam int LEN_W   = 16;
   localparam int DUTY_W  = 10;
   localparam int SINE_W  = 7;

   localparam logic [1:0] KIND_TICK   = 2'd0;
   localparam logic [1:0] KIND_DUAL   = 2'd1;
   localparam logic [1:0] KIND_SINGLE = 2'd2;

   localparam logic [DUTY_W-1:0] DUTY_OFFSET = 10'd319;
   localparam logic [15:0]       SINGLE_MULT = 16'd49250;

   typedef struct packed {
      logic [1:0]       kind;
      logic [3:0]       digit;
      logic [15:0]      frequency;
      logic [LEN_W-1:0] tone_length;
   } req_type;

   typedef struct packed {
      logic [DUTY_W-1:0] duty;
      logic              busy_res;
      logic              tone_end;
   } rsp_type;

   function automatic logic [SINE_W-1:0] sine_lookup(input logic [5:0] idx);
      logic [SINE_W-1:0] v;
      case (idx)
         6'd0:  v = 7'd50;   6'd1:  v = 7'd55;   6'd2:  v = 7'd60;   6'd3:  v = 7'd65;
         6'd4:  v = 7'd69;   6'd5:  v = 7'd74;   6'd6:  v = 7'd78;   6'd7:  v = 7'd82;
         6'd8:  v = 7'd85;   6'd9:  v = 7'd89;   6'd10: v = 7'd92;   6'd11: v = 7'd94;
         6'd12: v = 7'd96;   6'd13: v = 7'd98;   6'd14: v = 7'd99;   6'd15: v = 7'd100;
         6'd16: v = 7'd100;  6'd17: v = 7'd100;  6'd18: v = 7'd99;   6'd19: v = 7'd98;
         6'd20: v = 7'd96;   6'd21: v = 7'd94;   6'd22: v = 7'd92;   6'd23: v = 7'd89;
         6'd24: v = 7'd85;   6'd25: v = 7'd82;   6'd26: v = 7'd78;   6'd27: v = 7'd74;
         6'd28: v = 7'd69;   6'd29: v = 7'd65;   6'd30: v = 7'd60;   6'd31: v = 7'd55;
         6'd32: v = 7'd50;   6'd33: v = 7'd45;   6'd34: v = 7'd40;   6'd35: v = 7'd35;
         6'd36: v = 7'd31;   6'd37: v = 7'd26;   6'd38: v = 7'd22;   6'd39: v = 7'd18;
         6'd40: v = 7'd15;   6'd41: v = 7'd11;   6'd42: v = 7'd8;    6'd43: v = 7'd6;
         6'd44: v = 7'd4;    6'd45: v = 7'd2;    6'd46: v = 7'd1;    6'd47: v = 7'd0;
         6'd48: v = 7'd0;    6'd49: v = 7'd0;    6'd50: v = 7'd1;    6'd51: v = 7'd2;
         6'd52: v = 7'd4;    6'd53: v = 7'd6;    6'd54: v = 7'd8;    6'd55: v = 7'd11;
         6'd56: v = 7'd15;   6'd57: v = 7'd18;   6'd58: v = 7'd22;   6'd59: v = 7'd26;
         6'd60: v = 7'd31;   6'd61: v = 7'd35;   6'd62: v = 7'd40;   6'd63: v = 7'd45;
         default: v = 7'd0;
      endcase
      return v;
   endfunction

   // row (low group) tone steps per digit; digits 10 and 13 to 15 are silent
   function automatic logic [15:0] row_step(input logic [3:0] digit);
      logic [15:0] v;
      case (digit)
         4'd0, 4'd11, 4'd12: v = 16'd39468;
         4'd1, 4'd2, 4'd3:   v = 16'd29234;
         4'd4, 4'd5, 4'd6:   v = 16'd32296;
         4'd7, 4'd8, 4'd9:   v = 16'd35735;
         default:            v = 16'd0;
      endcase
      return v;
   endfunction

   function automatic logic [15:0] col_step(input logic [3:0] digit);
      logic [15:0] v;
      case (digit)
         4'd1, 4'd4, 4'd7, 4'd11: v = 16'd50709;
         4'd0, 4'd2, 4'd5, 4'd8:  v = 16'd56036;
         4'd3, 4'd6, 4'd9, 4'd12: v = 16'd61950;
         default:                 v = 16'd0;
      endcase
      return v;
   endfunction

endpackage

@@ design/dtmf_dual_tone_synth_top.sv @@
// channel | ports                           | payload
// --------+---------------------------------+--------------------------
// request | req_valid, req_stall, req_data  | dtmf_pkg::req_type
// result  | rsp_valid, rsp_stall, rsp_data  | dtmf_pkg::rsp_type
//
// One request per cycle while req_stall is low; its result is registered in the
// result register, or in the skid entry while a result waits. Critical path:
// 16x16 step multiply for single starts, or 24-bit phase add plus sine table and duty add for ticks.
// A two-entry output (result register plus skid) lets requests flow while a
// result waits; req_stall is high only when the skid entry is occupied.
// Synchronous active-high reset clears accumulators, steps, length and valids.
module dtmf_dual_tone_synth_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dtmf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dtmf_pkg::rsp_type rsp_data
);

   logic [dtmf_pkg::PHASE_W-1:0] phase_row_ff, phase_row_in;
   logic [dtmf_pkg::PHASE_W-1:0] phase_col_ff, phase_col_in;
   logic [dtmf_pkg::PHASE_W-1:0] step_row_ff, step_row_in;
   logic [dtmf_pkg::PHASE_W-1:0] step_col_ff, step_col_in;
   logic [dtmf_pkg::LEN_W-1:0]   ticks_left_ff, ticks_left_in;
   logic                         dual_mode_ff, dual_mode_in;

   logic              rsp_valid_ff, rsp_valid_in;
   dtmf_pkg::rsp_type rsp_ff, rsp_in;
   logic              skid_valid_ff, skid_valid_in;
   dtmf_pkg::rsp_type skid_ff, skid_in;

   logic                         req_accept;
   logic                         out_take;
   logic [31:0]                  single_prod;
   logic [dtmf_pkg::PHASE_W-1:0] row_sum;
   logic [dtmf_pkg::PHASE_W-1:0] col_sum;
   logic [dtmf_pkg::SINE_W-1:0]  sine_a;
   logic [dtmf_pkg::SINE_W-1:0]  sine_b;
   dtmf_pkg::rsp_type            result;

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !req_stall;
   assign out_take   = rsp_valid_ff && !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   assign single_prod = 32'(req_data.frequency) * 32'(dtmf_pkg::SINGLE_MULT);
   assign row_sum     = phase_row_ff + step_row_ff;
   assign col_sum     = phase_col_ff + step_col_ff;
   assign sine_a      = dtmf_pkg::sine_lookup(row_sum[21:16]);
   assign sine_b      = dtmf_pkg::sine_lookup(col_sum[21:16]);

   always_comb begin
      phase_row_in  = phase_row_ff;
      phase_col_in  = phase_col_ff;
      step_row_in   = step_row_ff;
      step_col_in   = step_col_ff;
      ticks_left_in = ticks_left_ff;
      dual_mode_in  = dual_mode_ff;
      result.duty     = '0;
      result.tone_end = 1'b0;
      if (req_accept) begin
         case (req_data.kind)
            dtmf_pkg::KIND_DUAL: begin
               step_row_in   = {6'd0, dtmf_pkg::row_step(req_data.digit), 2'b00};
               step_col_in   = {6'd0, dtmf_pkg::col_step(req_data.digit), 2'b00};
               phase_row_in  = '0;
               phase_col_in  = '0;
               ticks_left_in = req_data.tone_length;
               dual_mode_in  = 1'b1;
            end
            dtmf_pkg::KIND_SINGLE: begin
               step_row_in   = single_prod[31:8];
               step_col_in   = '0;
               phase_row_in  = '0;
               phase_col_in  = '0;
               ticks_left_in = req_data.tone_length;
               dual_mode_in  = 1'b0;
            end
            dtmf_pkg::KIND_TICK: begin
               if (ticks_left_ff != '0) begin
                  phase_row_in = row_sum;
                  if (dual_mode_ff) begin
                     phase_col_in = col_sum;
                     result.duty  = 10'(sine_a) + 10'(sine_b) + dtmf_pkg::DUTY_OFFSET;
                  end else begin
                     result.duty  = 10'({sine_a, 1'b0}) + dtmf_pkg::DUTY_OFFSET;
                  end
                  ticks_left_in   = ticks_left_ff - 16'd1;
                  result.tone_end = (ticks_left_ff == 16'd1);
               end
            end
            default: begin
            end
         endcase
      end
      result.busy_res = (ticks_left_in != '0);
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            rsp_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (req_accept) begin
         if (!rsp_valid_ff || out_take) begin
            rsp_in       = result;
            rsp_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_row_ff  <= '0;
         phase_col_ff  <= '0;
         step_row_ff   <= '0;
         step_col_ff   <= '0;
         ticks_left_ff <= '0;
         dual_mode_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         phase_row_ff  <= phase_row_in;
         phase_col_ff  <= phase_col_in;
         step_row_ff   <= step_row_in;
         step_col_ff   <= step_col_in;
         ticks_left_ff <= ticks_left_in;
         dual_mode_ff  <= dual_mode_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

`ifndef SYNTHESIS
   skid_needs_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry held while result register empty");

   end_is_final_tick: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.tone_end) |->
         (!rsp_ff.busy_res && rsp_ff.duty >= dtmf_pkg::DUTY_OFFSET))
      else $error("tone end with busy set or without a tone sample");

   idle_tick_holds_phase: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.kind == dtmf_pkg::KIND_TICK && ticks_left_ff == '0)
         |=> ($stable(phase_row_ff) && $stable(phase_col_ff) && ticks_left_ff == '0))
      else $error("tick with no tone left changed the accumulators");

   start_clears_phase: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_data.kind == dtmf_pkg::KIND_DUAL ||
                      req_data.kind == dtmf_pkg::KIND_SINGLE))
         |=> (phase_row_ff == '0 && phase_col_ff == '0))
      else $error("start request did not clear the accumulators");
`endif

endmodule

@@ dv/dtmf_checker.sv @@
module dtmf_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  dtmf_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  dtmf_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [9:0]  TONE_BIAS = 10'd319;
   localparam logic [31:0] SINGLE_K  = 32'd49250;

   // full-cycle sine table packed MSB-first: entry 0 sits in the top 7 bits
   localparam logic [64*7-1:0] SINE_ROM = {
      7'd50, 7'd55, 7'd60, 7'd65, 7'd69, 7'd74, 7'd78, 7'd82,
      7'd85, 7'd89, 7'd92, 7'd94, 7'd96, 7'd98, 7'd99, 7'd100,
      7'd100, 7'd100, 7'd99, 7'd98, 7'd96, 7'd94, 7'd92, 7'd89,
      7'd85, 7'd82, 7'd78, 7'd74, 7'd69, 7'd65, 7'd60, 7'd55,
      7'd50, 7'd45, 7'd40, 7'd35, 7'd31, 7'd26, 7'd22, 7'd18,
      7'd15, 7'd11, 7'd8, 7'd6, 7'd4, 7'd2, 7'd1, 7'd0,
      7'd0, 7'd0, 7'd1, 7'd2, 7'd4, 7'd6, 7'd8, 7'd11,
      7'd15, 7'd18, 7'd22, 7'd26, 7'd31, 7'd35, 7'd40, 7'd45
   };

   localparam logic [16*16-1:0] ROW_ROM = {
      16'd39468, 16'd29234, 16'd29234, 16'd29234, 16'd32296, 16'd32296, 16'd32296, 16'd35735,
      16'd35735, 16'd35735, 16'd0, 16'd39468, 16'd39468, 16'd0, 16'd0, 16'd0
   };

   localparam logic [16*16-1:0] COL_ROM = {
      16'd56036, 16'd50709, 16'd56036, 16'd61950, 16'd50709, 16'd56036, 16'd61950, 16'd50709,
      16'd56036, 16'd61950, 16'd0, 16'd50709, 16'd61950, 16'd0, 16'd0, 16'd0
   };

   logic [23:0] phase_a, phase_b, inc_a, inc_b;
   logic [15:0] remaining;
   logic        two_tone;

   dtmf_pkg::rsp_type duty_q[$];
   dtmf_pkg::rsp_type want;

   function automatic logic [9:0] sine_of(logic [23:0] ph);
      return {3'd0, SINE_ROM[(63 - ph[21:16]) * 7 +: 7]};
   endfunction

   function automatic dtmf_pkg::rsp_type advance_tone(dtmf_pkg::req_type r);
      dtmf_pkg::rsp_type o;
      logic [31:0]       prod;
      o = '0;
      case (r.kind)
         dtmf_pkg::KIND_DUAL: begin
            inc_a     = {6'd0, ROW_ROM[(15 - r.digit) * 16 +: 16], 2'b00};
            inc_b     = {6'd0, COL_ROM[(15 - r.digit) * 16 +: 16], 2'b00};
            phase_a   = '0;
            phase_b   = '0;
            remaining = r.tone_length;
            two_tone  = 1'b1;
         end
         dtmf_pkg::KIND_SINGLE: begin
            prod      = SINGLE_K * {16'd0, r.frequency};
            inc_a     = prod[31:8];
            inc_b     = '0;
            phase_a   = '0;
            phase_b   = '0;
            remaining = r.tone_length;
            two_tone  = 1'b0;
         end
         dtmf_pkg::KIND_TICK: begin
            if (remaining != 0) begin
               phase_a = phase_a + inc_a;
               if (two_tone) begin
                  phase_b = phase_b + inc_b;
                  o.duty  = sine_of(phase_a) + sine_of(phase_b) + TONE_BIAS;
               end else begin
                  o.duty  = (sine_of(phase_a) << 1) + TONE_BIAS;
               end
               remaining  = remaining - 16'd1;
               o.tone_end = (remaining == 0);
            end
         end
         default: ;
      endcase
      o.busy_res = (remaining != 0);
      return o;
   endfunction

   task automatic flag_error(string what);
      fail_count++;
      if (fail_count <= 10)
         $display("%0t dtmf_checker: %s", $realtime, what);
   endtask

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         phase_a   = '0;
         phase_b   = '0;
         inc_a     = '0;
         inc_b     = '0;
         remaining = '0;
         two_tone  = 1'b0;
         duty_q.delete();
      end else begin
         // response side first, since each result is registered
         if (rsp_valid && !rsp_stall) begin
            if (duty_q.size() == 0) begin
               flag_error($sformatf("unexpected response duty=%0d busy=%0b end=%0b",
                                    rsp_data.duty, rsp_data.busy_res, rsp_data.tone_end));
            end else begin
               want = duty_q.pop_front();
               if (rsp_data.duty !== want.duty || rsp_data.busy_res !== want.busy_res ||
                   rsp_data.tone_end !== want.tone_end)
                  flag_error($sformatf(
                     "exp duty=%0d busy=%0b end=%0b, got duty=%0d busy=%0b end=%0b",
                     want.duty, want.busy_res, want.tone_end,
                     rsp_data.duty, rsp_data.busy_res, rsp_data.tone_end));
            end
         end
         if (req_valid && !req_stall)
            duty_q.push_back(advance_tone(req_data));
      end
      outstanding <= duty_q.size();
   end

endmodule

@@ dv/tb_top.sv @@
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] KIND_UNUSED  = 2'd3;
   localparam int         RANDOM_ITEMS = 1900;
   localparam int         CYCLE_LIMIT  = 200000;
   localparam int         TAIL_CYCLES  = 10;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   dtmf_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   dtmf_pkg::rsp_type rsp_data;

   int      fail_count;
   int      outstanding;
   int      cycles;
   int      sent;
   logic    calm;

   dtmf_dual_tone_synth_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   dtmf_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !calm && ($urandom_range(0, 99) < 24);
      end
   end

   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("[dtmf_dual_tone_synth_top] ERROR");
      $finish;
   end

   function automatic dtmf_pkg::req_type mk(logic [1:0] k, logic [3:0] d, logic [15:0] f,
                                            logic [15:0] len);
      dtmf_pkg::req_type r;
      r.kind        = k;
      r.digit       = d;
      r.frequency   = f;
      r.tone_length = len;
      return r;
   endfunction

   function automatic dtmf_pkg::req_type tick_item();
      return mk(dtmf_pkg::KIND_TICK, 4'($urandom), 16'($urandom), 16'($urandom));
   endfunction

   task automatic send(dtmf_pkg::req_type r);
      while (!calm && $urandom_range(0, 99) < 24) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      if (r.kind != KIND_UNUSED)
         sent++;
   endtask

   // hold requests back until every outstanding response has come out
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
   endtask

   initial begin
      int                n, len, pick, i;
      logic              paused_a, paused_b;
      dtmf_pkg::req_type st;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_stall = 1'b0;
      calm      = 1'b0;
      sent      = 0;
      paused_a  = 1'b0;
      paused_b  = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: idle ticks, table edges, replacement, zero length, extremes
      send(mk(dtmf_pkg::KIND_TICK, 4'd0, 16'd0, 16'd0));
      send(mk(KIND_UNUSED, 4'hf, 16'hffff, 16'hffff));
      send(mk(dtmf_pkg::KIND_DUAL, 4'd0, 16'd0, 16'd3));
      repeat (4) send(tick_item());
      send(mk(dtmf_pkg::KIND_DUAL, 4'd12, 16'hffff, 16'd2));
      send(tick_item());
      send(mk(dtmf_pkg::KIND_DUAL, 4'd15, 16'd0, 16'd1));
      send(tick_item());
      send(tick_item());
      send(mk(dtmf_pkg::KIND_SINGLE, 4'd0, 16'hffff, 16'hffff));
      send(tick_item());
      send(tick_item());
      send(mk(KIND_UNUSED, 4'd0, 16'd0, 16'd0));
      send(mk(dtmf_pkg::KIND_SINGLE, 4'hf, 16'd0, 16'd0));
      send(tick_item());
      send(mk(dtmf_pkg::KIND_SINGLE, 4'd5, 16'd1000, 16'd1));
      send(tick_item());
      send(mk(dtmf_pkg::KIND_DUAL, 4'd10, 16'd0, 16'd1));
      send(tick_item());
      drain();

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         calm <= (sent >= 700 && sent < 1100);
         if (!paused_a && sent >= 450) begin
            paused_a = 1'b1;
            drain();
         end
         if (!paused_b && sent >= 1400) begin
            paused_b = 1'b1;
            drain();
         end
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            // raw noise, any kind including the unused code
            send(mk(2'($urandom), 4'($urandom), 16'($urandom), 16'($urandom)));
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
               len = $urandom_range(0, 65535);
            else if (pick < 10)
               len = 0;
            else
               len = $urandom_range(1, 30);
            st = mk(($urandom_range(0, 1) == 0) ? dtmf_pkg::KIND_DUAL : dtmf_pkg::KIND_SINGLE,
                    4'($urandom_range(0, 15)), 16'($urandom), 16'(len));
            send(st);
            n = (len > 36) ? 36 : len + $urandom_range(0, 3);
            if ($urandom_range(0, 9) == 0)
               n = $urandom_range(0, n);  // cut short, next start replaces the tone
            for (i = 0; i < n; i++) begin
               if ($urandom_range(0, 99) < 3)
                  send(mk(KIND_UNUSED, 4'($urandom), 16'($urandom), 16'($urandom)));
               send(tick_item());
            end
         end
      end

      req_valid <= 1'b0;
      calm      <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0 && outstanding == 0) begin
         $display("[dtmf_dual_tone_synth_top] OK");
      end else begin
         $display("[dtmf_dual_tone_synth_top] ERROR");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
design/dtmf_pkg.sv
design/dtmf_dual_tone_synth_top.sv
dv/dtmf_checker.sv
dv/tb_top.sv
